@@ rtl/core/sliding_median_filter_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the sliding median filter checkers
// ---------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/smf_pkg.sv @@
// ---------------------------------------------------------------------------
// smf_pkg
// Types and defaults shared by the sliding median filter modules.
// ---------------------------------------------------------------------------
package smf_pkg;

    localparam int WINDOW_DEF      = 5;
    localparam int CHANNELS_DEF    = 2;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CHAN_BITS       = 1;
    localparam int MEDIAN_BITS     = 16;

    typedef struct packed {
        logic [CHAN_BITS-1:0]   channel;
        logic [MEDIAN_BITS-1:0] sample;
    } in_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0]   channel_out;
        logic [MEDIAN_BITS-1:0] median;
    } out_t;

    // Control from the sequencer to the selection engine
    typedef struct packed {
        logic load;
    } sel_ctl_t;

    // Status back from the selection engine
    typedef struct packed {
        logic busy;
        logic done;
    } sel_sts_t;

endpackage

@@ rtl/core/smf_ram.sv @@
// ---------------------------------------------------------------------------
// smf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module smf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/smf_select.sv @@
// ---------------------------------------------------------------------------
// smf_select
// Bit-serial rank selection: shifts the window out MSB first and resolves
// one bit of the middle element per cycle.
// ---------------------------------------------------------------------------
module smf_select #(
    parameter int WINDOW      = smf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smf_pkg::sel_ctl_t             ctl,
    input  logic [WINDOW*SAMPLE_BITS-1:0] row,
    output smf_pkg::sel_sts_t             sts,
    output logic [SAMPLE_BITS-1:0]        median
);

    localparam int CW   = $clog2(WINDOW + 1);
    localparam int NW   = $clog2(SAMPLE_BITS + 1);
    localparam int RANK = WINDOW / 2;

    logic [SAMPLE_BITS-1:0] sh_reg [WINDOW];
    logic [WINDOW-1:0]      alive_reg;
    logic [CW-1:0]          rank_reg;
    logic [SAMPLE_BITS-1:0] med_reg;
    logic [NW-1:0]          cnt_reg;
    logic [NW-1:0]          cnt_next;
    logic [CW-1:0]          zeros;
    logic [WINDOW-1:0]      msb;
    logic                   bit_q;
    logic                   busy;

    assign busy = (cnt_reg != '0);

    // Count live candidates whose current bit is zero
    always_comb
    begin
        zeros = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            msb[i] = sh_reg[i][SAMPLE_BITS-1];
            zeros  = zeros + CW'(alive_reg[i] & ~sh_reg[i][SAMPLE_BITS-1]);
        end
        bit_q = (rank_reg >= zeros);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.load)
        begin
            cnt_next = NW'(SAMPLE_BITS);
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                sh_reg[i] <= row[i*SAMPLE_BITS +: SAMPLE_BITS];
            end
            alive_reg <= '1;
            rank_reg  <= CW'(RANK);
        end
        else if (busy)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                sh_reg[i] <= sh_reg[i] << 1;
            end
            // drop the candidates on the wrong side of the resolved bit
            if (bit_q)
            begin
                alive_reg <= alive_reg & msb;
                rank_reg  <= rank_reg - zeros;
            end
            else
            begin
                alive_reg <= alive_reg & ~msb;
            end
            med_reg <= {med_reg[SAMPLE_BITS-2:0], bit_q};
        end
    end

    assign sts.busy = busy;
    assign sts.done = busy && (cnt_reg == NW'(1));
    assign median   = med_reg;

endmodule

@@ rtl/core/sliding_median_filter_unit.sv @@
// ---------------------------------------------------------------------------
// sliding_median_filter_unit
// Two-channel running median over the last WINDOW samples of each channel.
// ---------------------------------------------------------------------------
// Flow: accept reads the channel's row from a row-per-channel RAM; ST_LOAD
//   writes the sample into its oldest slot and starts the engine, which
//   resolves one median bit per cycle in ST_SHIFT. A channel failing ch_ok
//   skips to ST_DONE with a zero median; one transaction at a time.
// Reset: windows read as zero and write slots restart at zero; no clearing
//   pass, a per-channel valid bit masks rows never written.
module sliding_median_filter_unit #(
    parameter int WINDOW      = smf_pkg::WINDOW_DEF,
    parameter int CHANNELS    = smf_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    output logic          sample_stall,
    input  smf_pkg::in_t  sample_data,
    output logic          median_valid,
    input  logic          median_stall,
    output smf_pkg::out_t median_data
);

    localparam int CAW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RW  = WINDOW * SAMPLE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [CHANNELS-1:0]             vld_reg;
    logic [SW-1:0]                   slot_reg [CHANNELS];
    logic                            out_vld_reg;
    smf_pkg::out_t                   out_data_reg;
    logic [smf_pkg::CHAN_BITS-1:0]   ch_reg;
    logic [SAMPLE_BITS-1:0]          smp_reg;
    logic                            ok_reg;

    logic                            accept;
    logic                            ch_ok;
    logic                            out_free;
    logic [CAW-1:0]                  addr;
    logic [SW-1:0]                   slot_cur;
    logic [SW-1:0]                   slot_adv;
    logic [RW-1:0]                   ram_rd;
    logic [RW-1:0]                   row_cur;
    logic [RW-1:0]                   row_new;
    logic [SAMPLE_BITS-1:0]          med;
    logic [31:0]                     med_wide;
    logic [31:0]                     smp_wide;
    smf_pkg::sel_ctl_t               sel_ctl;
    smf_pkg::sel_sts_t               sel_sts;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign ch_ok        = (CHANNELS > 1) || (sample_data.channel == '0);
    assign out_free     = !out_vld_reg || !median_stall;
    assign addr         = CAW'(ch_reg);
    assign slot_cur     = slot_reg[addr];
    assign slot_adv     = (slot_cur == SW'(WINDOW - 1)) ? '0 : slot_cur + SW'(1);
    assign smp_wide     = 32'(sample_data.sample);
    assign med_wide     = 32'(med);
    assign sel_ctl.load = (state_reg == ST_LOAD);

    // Insert the new sample into the oldest slot of the fetched row
    always_comb
    begin
        row_cur = vld_reg[addr] ? ram_rd : '0;
        row_new = row_cur;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (slot_cur == SW'(i))
            begin
                row_new[i*SAMPLE_BITS +: SAMPLE_BITS] = smp_reg;
            end
        end
    end

    smf_ram #(
        .WIDTH (RW),
        .DEPTH (CHANNELS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (sel_ctl.load),
        .wr_addr (addr),
        .wr_data (row_new),
        .rd_en   (accept),
        .rd_addr (CAW'(sample_data.channel)),
        .rd_data (ram_rd)
    );

    smf_select #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_select (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (sel_ctl),
        .row    (row_new),
        .sts    (sel_sts),
        .median (med)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ch_ok ? ST_LOAD : ST_DONE;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (sel_sts.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                slot_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD)
            begin
                vld_reg[addr]  <= 1'b1;
                slot_reg[addr] <= slot_adv;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!median_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= sample_data.channel;
            smp_reg <= smp_wide[SAMPLE_BITS-1:0];
            ok_reg  <= ch_ok;
        end
        // hold the result while the transaction is stalled
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg.channel_out <= ch_reg;
            out_data_reg.median      <= ok_reg ? med_wide[smf_pkg::MEDIAN_BITS-1:0] : '0;
        end
    end

    assign median_valid = out_vld_reg;
    assign median_data  = out_data_reg;

endmodule

@@ rtl/core/smf_checker.sv @@
// ---------------------------------------------------------------------------
// smf_checker
// Port-level checks of the sliding median filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "sliding_median_filter_unit_defines.svh"

module smf_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          sample_valid,
    input logic          sample_stall,
    input logic          median_valid,
    input logic          median_stall,
    input smf_pkg::out_t median_data
);

    // a stalled result holds until taken
    `SMF_ASSERT_NEXT(a_out_hold, median_valid && median_stall, median_valid && $stable(median_data), "median transaction changed while stalled")

    // one transaction in flight: the input closes right after an accept
    `SMF_ASSERT_NEXT(a_one_in_flight, sample_valid && !sample_stall, sample_stall, "second sample accepted while busy")

    // a result only appears after the block has been busy
    `SMF_ASSERT_NOW(a_result_after_work, $rose(median_valid), $past(sample_stall), "result appeared without a transaction in flight")

endmodule

bind sliding_median_filter_unit smf_checker u_smf_checker (.*);

@@ tb/sv/sliding_median_filter_unit_tb.sv @@
// ---------------------------------------------------------------------------
// sliding_median_filter_unit_tb
// Self-checking bench for the two-channel running median filter. A clocked
// driver feeds sample transactions from a queue, a behavioural copy of both
// windows predicts each median on acceptance, and a clocked monitor checks
// every median transaction against the oldest prediction. Both sides insert
// random gaps; the receiver also holds off for one long stretch.
// ---------------------------------------------------------------------------
module sliding_median_filter_unit_tb;

    localparam int WIN          = smf_pkg::WINDOW_DEF;
    localparam int CHANS        = smf_pkg::CHANNELS_DEF;
    localparam int SBITS        = smf_pkg::SAMPLE_BITS_DEF;
    localparam int CBITS        = smf_pkg::CHAN_BITS;
    localparam int MBITS        = smf_pkg::MEDIAN_BITS;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_AT     = 350;
    localparam int HOLD_AT      = 1500;
    localparam int HOLD_LEN     = 400;
    localparam int QUIET_FROM   = 9000;
    localparam int QUIET_TO     = 12000;
    localparam int GAP_PCT      = 12;
    localparam int TAIL_CYCLES  = 40;

    typedef struct {
        smf_pkg::in_t txn;
        bit           drain_first;
    } pending_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          sample_valid = 1'b0;
    logic          sample_stall;
    smf_pkg::in_t  sample_data  = '0;
    logic          median_valid;
    logic          median_stall = 1'b0;
    smf_pkg::out_t median_data;

    pending_t      pending_q[$];
    smf_pkg::out_t median_exp_q[$];

    logic [CHANS-1:0][WIN-1:0][SBITS-1:0] window_mem;
    int unsigned write_slot [CHANS];

    int unsigned cycle_cnt = 0;
    int unsigned fail_cnt  = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    sliding_median_filter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .median_valid (median_valid),
        .median_stall (median_stall),
        .median_data  (median_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
            cycle_cnt <= cycle_cnt + 1;
    end

    // Random gap, suppressed across the quiet stretch
    function automatic bit take_gap();
        if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO)
            return 1'b0;
        return ($urandom_range(99) < GAP_PCT);
    endfunction

    // Sort a copy of the window ascending and take the middle entry
    function automatic logic [MBITS-1:0] median_of(logic [WIN-1:0][SBITS-1:0] win);
        logic [WIN-1:0][SBITS-1:0] srt;
        logic [SBITS-1:0]          tmp;
        srt = win;
        for (int pass = 0; pass < WIN; pass++)
        begin
            for (int k = 0; k + 1 < WIN; k++)
            begin
                if (srt[k] > srt[k+1])
                begin
                    tmp      = srt[k];
                    srt[k]   = srt[k+1];
                    srt[k+1] = tmp;
                end
            end
        end
        return MBITS'(srt[WIN/2]);
    endfunction

    // Update the channel's window and return the median it should report
    function automatic smf_pkg::out_t predict_median(smf_pkg::in_t txn);
        smf_pkg::out_t res;
        int unsigned   ch;
        ch              = 32'(txn.channel);
        res.channel_out = txn.channel;
        res.median      = '0;
        if (ch < CHANS)
        begin
            window_mem[ch][write_slot[ch]] = txn.sample[SBITS-1:0];
            write_slot[ch] = (write_slot[ch] + 1 >= WIN) ? 0 : write_slot[ch] + 1;
            res.median     = median_of(window_mem[ch]);
        end
        return res;
    endfunction

    task automatic queue_sample(input logic [CBITS-1:0] ch,
                                input logic [MBITS-1:0] smp,
                                input bit drain);
        pending_t p;
        p.txn.channel = ch;
        p.txn.sample  = smp;
        p.drain_first = drain;
        pending_q.push_back(p);
    endtask

    // Driver: predict on acceptance, then offer the next pending transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_data  <= '0;
        end
        else
        begin : drive
            logic         nxt_valid;
            smf_pkg::in_t nxt_data;
            nxt_valid = sample_valid;
            nxt_data  = sample_data;
            if (sample_valid && !sample_stall)
            begin
                median_exp_q.push_back(predict_median(sample_data));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_q.size() > 0 && !take_gap())
            begin
                // hold a drain point until every outstanding median has come back
                if (!pending_q[0].drain_first || median_exp_q.size() == 0)
                begin
                    nxt_data  = pending_q[0].txn;
                    nxt_valid = 1'b1;
                    pending_q.pop_front();
                end
            end
            sample_valid <= nxt_valid;
            sample_data  <= nxt_data;
        end
    end

    // Monitor: check each median transaction, then choose the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_stall <= 1'b0;
        end
        else
        begin : watch
            smf_pkg::out_t want;
            if (median_valid && !median_stall)
            begin
                if (median_exp_q.size() == 0)
                begin
                    $error("unexpected median transaction: channel_out %0d median %0d",
                           median_data.channel_out, median_data.median);
                    fail_cnt++;
                end
                else
                begin
                    want = median_exp_q.pop_front();
                    if (median_data.channel_out !== want.channel_out)
                    begin
                        $error("channel_out: expected %0d, actual %0d",
                               want.channel_out, median_data.channel_out);
                        fail_cnt++;
                    end
                    if (median_data.median !== want.median)
                    begin
                        $error("median: expected %0d, actual %0d",
                               want.median, median_data.median);
                        fail_cnt++;
                    end
                end
            end
            if (!hold_done && cycle_cnt >= HOLD_AT)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                median_stall <= 1'b1;
            end
            else
                median_stall <= take_gap();
        end
    end

    initial
    begin : main
        int unsigned      count;
        int unsigned      burst;
        int unsigned      ch_mode;
        int unsigned      val_mode;
        logic [CBITS-1:0] ch;
        logic [MBITS-1:0] smp;
        logic [MBITS-1:0] base;

        window_mem = '0;
        for (int c = 0; c < CHANS; c++)
            write_slot[c] = 0;

        // Zeros left by reset outvote the first samples
        queue_sample(1'b0, 16'hFFFF, 1'b0);
        queue_sample(1'b1, 16'h0001, 1'b0);
        queue_sample(1'b0, 16'hFFFF, 1'b0);
        queue_sample(1'b0, 16'hFFFF, 1'b0);
        queue_sample(1'b0, 16'h8000, 1'b0);
        queue_sample(1'b0, 16'h7FFF, 1'b0);
        // Wrap of the write slot on the left channel
        queue_sample(1'b0, 16'h0000, 1'b0);
        queue_sample(1'b0, 16'h0000, 1'b0);
        for (int i = 0; i < 4; i++)
            queue_sample(1'b1, 16'hFFFF, 1'b0);
        for (int i = 0; i < 5; i++)
            queue_sample(1'b1, 16'h0000, 1'b0);
        // Ties on the right channel
        queue_sample(1'b1, 16'h0005, 1'b0);
        queue_sample(1'b1, 16'h0005, 1'b0);
        queue_sample(1'b1, 16'h0003, 1'b0);
        queue_sample(1'b0, 16'h5555, 1'b0);
        queue_sample(1'b0, 16'hAAAA, 1'b0);
        queue_sample(1'b0, 16'h5555, 1'b0);
        queue_sample(1'b1, 16'hAAAA, 1'b0);
        queue_sample(1'b1, 16'hFFFE, 1'b0);

        count = 0;
        while (count < RANDOM_ITEMS)
        begin
            burst    = $urandom_range(12, 1);
            ch_mode  = $urandom_range(2);
            val_mode = $urandom_range(9);
            ch       = CBITS'($urandom_range(1));
            base     = MBITS'($urandom);
            for (int i = 0; i < burst && count < RANDOM_ITEMS; i++)
            begin
                case (ch_mode)
                    0: ch = ch;
                    1: ch = ~ch;
                    default: ch = CBITS'($urandom_range(1));
                endcase
                if (val_mode < 5)
                    smp = MBITS'($urandom);
                else if (val_mode < 7)
                    smp = base + MBITS'($urandom_range(15));
                else if (val_mode < 9)
                    smp = MBITS'($urandom_range(7));
                else
                    smp = $urandom_range(1) ? 16'hFFFF - MBITS'($urandom_range(1))
                                            : MBITS'($urandom_range(1));
                queue_sample(ch, smp, (count == 0 || count == DRAIN_AT));
                count++;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() > 0 || sample_valid)
            @(posedge clk);
        while (median_exp_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule
